### hw/rtl/bol_pkg.sv
package bol_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW         = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [AW-1:0]                t_addr;
    typedef logic [CW-1:0]                t_cnt;

    localparam logic [3:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [3:0] CMD_PUSH_FRONT = 4'd1;
    localparam logic [3:0] CMD_POP_BACK   = 4'd2;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd3;
    localparam logic [3:0] CMD_READ_POS   = 4'd4;
    localparam logic [3:0] CMD_FIND       = 4'd5;
    localparam logic [3:0] CMD_DELETE     = 4'd6;
    localparam logic [3:0] CMD_INSERT     = 4'd7;
    localparam logic [3:0] CMD_SORT       = 4'd8;
    localparam logic [3:0] CMD_REVERSE    = 4'd9;
    localparam logic [3:0] CMD_CLEAR      = 4'd10;

endpackage

### hw/rtl/bounded_ordered_list_engine.sv
// Bounded ordered list engine: keeps up to bol_pkg::CAPACITY signed words in
// positions 1..count of a single-port-write, single-port-read memory and runs
// one command per request. A request is taken when i_start is high and o_busy
// is low; its single result appears for exactly one cycle with o_strobe high
// and cannot be held off, so the receiver must capture it in that cycle.
// Commands answered straight from idle, without raising o_busy: push_back,
// pop_back, clear, unknown codes, reverse of one element or none, and any
// command refused at once (full, empty, position out of range). Others
// step through memory: read_pos reads one entry; find, delete and
// insert_sorted scan forward; push_front and insert_sorted shift entries up;
// delete and pop_front shift the tail down; reverse swaps pairs inward;
// sort is an insertion sort. Each element moved or compared costs a
// registered memory read, and each one moved a write. o_busy stays high
// until the result cycle, and a new request may be taken in that same cycle.
module bounded_ordered_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_command,
    input  logic signed [31:0] i_item_value,
    input  logic [6:0]  i_item_position,
    output logic        o_strobe,
    output logic        o_ok,
    output logic signed [31:0] o_read_value,
    output logic [6:0]  o_found_position,
    output logic [6:0]  o_element_count
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_UP_RD    = 4'd3;
    localparam logic [3:0] S_UP_WR    = 4'd4;
    localparam logic [3:0] S_DN_RD    = 4'd5;
    localparam logic [3:0] S_DN_WR    = 4'd6;
    localparam logic [3:0] S_RDP      = 4'd7;
    localparam logic [3:0] S_KEY_RD   = 4'd8;
    localparam logic [3:0] S_KEY      = 4'd9;
    localparam logic [3:0] S_SORT_RD  = 4'd10;
    localparam logic [3:0] S_SORT_CMP = 4'd11;
    localparam logic [3:0] S_REV_RD1  = 4'd12;
    localparam logic [3:0] S_REV_RD2  = 4'd13;
    localparam logic [3:0] S_REV_WR1  = 4'd14;
    localparam logic [3:0] S_REV_WR2  = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [3:0]    r_cmd, n_cmd;
    bol_pkg::t_data r_val, n_val;
    bol_pkg::t_data r_key, n_key;
    bol_pkg::t_data r_tmp, n_tmp;
    bol_pkg::t_cnt r_cnt, n_cnt;
    bol_pkg::t_cnt r_i, n_i;
    bol_pkg::t_cnt r_j, n_j;
    logic          r_strobe, n_strobe;
    logic          r_ok, n_ok;
    logic signed [31:0] r_rd, n_rd;
    logic [6:0]    r_fp, n_fp;

    logic           we, re;
    bol_pkg::t_addr waddr, raddr;
    bol_pkg::t_data wdata, rdata;
    logic           match;

    bol_ram #(
        .DEPTH (bol_pkg::CAPACITY),
        .WIDTH (bol_pkg::DATA_WIDTH),
        .AW    (bol_pkg::AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Find and delete stop on equality; insert stops at the first element
    // that is not smaller than the new value.
    always_comb begin
        if (r_cmd == bol_pkg::CMD_INSERT) begin
            match = !(r_val > rdata);
        end else begin
            match = (rdata == r_val);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_key    = r_key;
        n_tmp    = r_tmp;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_j      = r_j;
        n_strobe = 1'b0;
        n_ok     = r_ok;
        n_rd     = r_rd;
        n_fp     = r_fp;
        we       = 1'b0;
        re       = 1'b0;
        waddr    = r_j[bol_pkg::AW-1:0];
        raddr    = r_i[bol_pkg::AW-1:0];
        wdata    = rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_command;
                    n_val = bol_pkg::DATA_WIDTH'(i_item_value);
                    n_ok  = 1'b0;
                    n_rd  = '0;
                    n_fp  = '0;
                    n_i   = '0;
                    case (i_command)
                        bol_pkg::CMD_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (32'(r_cnt) < 32'(bol_pkg::CAPACITY)) begin
                                we    = 1'b1;
                                waddr = r_cnt[bol_pkg::AW-1:0];
                                wdata = bol_pkg::DATA_WIDTH'(i_item_value);
                                n_cnt = r_cnt + 1'b1;
                                n_ok  = 1'b1;
                            end
                        end
                        bol_pkg::CMD_PUSH_FRONT: begin
                            if (32'(r_cnt) < 32'(bol_pkg::CAPACITY)) begin
                                n_j     = r_cnt;
                                n_state = S_UP_RD;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        bol_pkg::CMD_POP_BACK: begin
                            n_strobe = 1'b1;
                            if (r_cnt != '0) begin
                                n_cnt = r_cnt - 1'b1;
                                n_ok  = 1'b1;
                            end
                        end
                        bol_pkg::CMD_POP_FRONT: begin
                            if (r_cnt != '0) begin
                                n_j     = '0;
                                n_state = S_DN_RD;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        bol_pkg::CMD_READ_POS: begin
                            if (i_item_position != '0 &&
                                32'(i_item_position) <= 32'(r_cnt)) begin
                                re      = 1'b1;
                                raddr   = bol_pkg::AW'(32'(i_item_position) - 32'd1);
                                n_state = S_RDP;
                            end else begin
                                n_rd     = '1;
                                n_strobe = 1'b1;
                            end
                        end
                        bol_pkg::CMD_FIND, bol_pkg::CMD_DELETE: begin
                            n_state = S_SCAN_RD;
                        end
                        bol_pkg::CMD_INSERT: begin
                            if (32'(r_cnt) < 32'(bol_pkg::CAPACITY)) begin
                                n_state = S_SCAN_RD;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        bol_pkg::CMD_SORT: begin
                            n_i     = bol_pkg::CW'(1);
                            n_state = S_KEY_RD;
                        end
                        bol_pkg::CMD_REVERSE: begin
                            if (r_cnt > bol_pkg::CW'(1)) begin
                                n_j     = r_cnt - 1'b1;
                                n_state = S_REV_RD1;
                            end else begin
                                n_ok     = 1'b1;
                                n_strobe = 1'b1;
                            end
                        end
                        bol_pkg::CMD_CLEAR: begin
                            n_cnt    = '0;
                            n_ok     = 1'b1;
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            // Walk forward until a match or the end of the list.
            S_SCAN_RD: begin
                if (r_i == r_cnt) begin
                    if (r_cmd == bol_pkg::CMD_INSERT) begin
                        n_j     = r_cnt;
                        n_state = S_UP_RD;
                    end else begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    re      = 1'b1;
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (match) begin
                    case (r_cmd)
                        bol_pkg::CMD_FIND: begin
                            n_fp     = 7'(r_i + 1'b1);
                            n_ok     = 1'b1;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end
                        bol_pkg::CMD_DELETE: begin
                            n_j     = r_i;
                            n_state = S_DN_RD;
                        end
                        default: begin
                            n_j     = r_cnt;
                            n_state = S_UP_RD;
                        end
                    endcase
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end

            // Open a gap at r_i: shift entries r_i..count-1 up by one.
            S_UP_RD: begin
                if (r_j == r_i) begin
                    we       = 1'b1;
                    waddr    = r_i[bol_pkg::AW-1:0];
                    wdata    = r_val;
                    n_cnt    = r_cnt + 1'b1;
                    n_ok     = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr   = bol_pkg::AW'(r_j - 1'b1);
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                we      = 1'b1;
                n_j     = r_j - 1'b1;
                n_state = S_UP_RD;
            end

            // Close the gap at r_j: shift the tail down by one.
            S_DN_RD: begin
                if (32'(r_j) + 32'd1 >= 32'(r_cnt)) begin
                    n_cnt    = r_cnt - 1'b1;
                    n_ok     = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr   = bol_pkg::AW'(r_j + 1'b1);
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                we      = 1'b1;
                n_j     = r_j + 1'b1;
                n_state = S_DN_RD;
            end

            S_RDP: begin
                n_rd     = 32'(rdata);
                n_ok     = 1'b1;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            // Insertion sort: hold the key, slide larger entries up.
            S_KEY_RD: begin
                if (r_i >= r_cnt) begin
                    n_ok     = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    re      = 1'b1;
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                n_key   = rdata;
                n_j     = r_i;
                n_state = S_SORT_RD;
            end
            S_SORT_RD: begin
                if (r_j == '0) begin
                    we      = 1'b1;
                    wdata   = r_key;
                    n_i     = r_i + 1'b1;
                    n_state = S_KEY_RD;
                end else begin
                    re      = 1'b1;
                    raddr   = bol_pkg::AW'(r_j - 1'b1);
                    n_state = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                we = 1'b1;
                if (rdata > r_key) begin
                    n_j     = r_j - 1'b1;
                    n_state = S_SORT_RD;
                end else begin
                    wdata   = r_key;
                    n_i     = r_i + 1'b1;
                    n_state = S_KEY_RD;
                end
            end

            // Reverse: swap the entries at r_i and r_j, then move inward.
            S_REV_RD1: begin
                if (r_i >= r_j) begin
                    n_ok     = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    re      = 1'b1;
                    n_state = S_REV_RD2;
                end
            end
            S_REV_RD2: begin
                n_tmp   = rdata;
                re      = 1'b1;
                raddr   = r_j[bol_pkg::AW-1:0];
                n_state = S_REV_WR1;
            end
            S_REV_WR1: begin
                we      = 1'b1;
                waddr   = r_i[bol_pkg::AW-1:0];
                n_state = S_REV_WR2;
            end
            S_REV_WR2: begin
                we      = 1'b1;
                wdata   = r_tmp;
                n_i     = r_i + 1'b1;
                n_j     = r_j - 1'b1;
                n_state = S_REV_RD1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_val <= n_val;
        r_key <= n_key;
        r_tmp <= n_tmp;
        r_i   <= n_i;
        r_j   <= n_j;
        r_ok  <= n_ok;
        r_rd  <= n_rd;
        r_fp  <= n_fp;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_ok             = r_ok;
    assign o_read_value     = r_rd;
    assign o_found_position = r_fp;
    assign o_element_count  = 7'(r_cnt);

endmodule

### hw/rtl/bol_ram.sv
module bol_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [3:0] CMD_UNKNOWN_LO = 4'd11;
    localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
    localparam int         LIST_DEPTH     = bol_pkg::CAPACITY;
    localparam int         RANDOM_ITEMS   = 1030;

    typedef struct {
        logic              ok;
        logic signed [31:0] read_value;
        logic [6:0]        found_position;
        logic [6:0]        element_count;
    } t_list_result;

    typedef struct {
        logic [3:0]        command;
        logic signed [31:0] value;
        logic [6:0]        position;
        bit                typed;
        t_list_result      want;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [3:0]         i_command;
    logic signed [31:0] i_item_value;
    logic [6:0]         i_item_position;
    logic               o_strobe;
    logic               o_ok;
    logic signed [31:0] o_read_value;
    logic [6:0]         o_found_position;
    logic [6:0]         o_element_count;

    // Typed expectation that rides along with the request being driven
    bit                 row_typed;
    t_list_result       row_want;

    t_list_result       pending_results[$];
    int                 failures;
    bit                 no_idle;

    // Shadow list held by the predictor
    logic signed [31:0] shadow_list[LIST_DEPTH];
    int                 shadow_count;

    bounded_ordered_list_engine uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_item_value    (i_item_value),
        .i_item_position (i_item_position),
        .o_strobe        (o_strobe),
        .o_ok            (o_ok),
        .o_read_value    (o_read_value),
        .o_found_position(o_found_position),
        .o_element_count (o_element_count)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Apply one command to the shadow list and return the result it gives.
    function automatic t_list_result apply_list_command(logic [3:0] cmd,
                                                        logic signed [31:0] v,
                                                        logic [6:0] pos);
        t_list_result       r;
        int                 i;
        int                 j;
        logic signed [31:0] key;
        r.ok = 1'b0;
        r.read_value = '0;
        r.found_position = '0;
        case (cmd)
            bol_pkg::CMD_PUSH_BACK: begin
                if (shadow_count < LIST_DEPTH) begin
                    shadow_list[shadow_count] = v;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            bol_pkg::CMD_PUSH_FRONT: begin
                if (shadow_count < LIST_DEPTH) begin
                    for (i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[0] = v;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            bol_pkg::CMD_POP_BACK: begin
                if (shadow_count > 0) begin
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            bol_pkg::CMD_POP_FRONT: begin
                if (shadow_count > 0) begin
                    for (i = 0; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            bol_pkg::CMD_READ_POS: begin
                if (pos >= 1 && pos <= shadow_count) begin
                    r.read_value = shadow_list[pos-1];
                    r.ok = 1'b1;
                end else begin
                    r.read_value = -32'sd1;
                end
            end
            bol_pkg::CMD_FIND, bol_pkg::CMD_DELETE: begin
                j = -1;
                for (i = 0; i < shadow_count && j < 0; i++)
                    if (shadow_list[i] == v) j = i;
                if (j >= 0) begin
                    r.ok = 1'b1;
                    if (cmd == bol_pkg::CMD_FIND) begin
                        r.found_position = 7'(j + 1);
                    end else begin
                        for (i = j; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i+1];
                        shadow_count--;
                    end
                end
            end
            bol_pkg::CMD_INSERT: begin
                if (shadow_count < LIST_DEPTH) begin
                    j = 0;
                    while (j < shadow_count && v > shadow_list[j]) j++;
                    for (i = shadow_count; i > j; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[j] = v;
                    shadow_count++;
                    r.ok = 1'b1;
                end
            end
            bol_pkg::CMD_SORT: begin
                for (i = 1; i < shadow_count; i++) begin
                    key = shadow_list[i];
                    j = i;
                    while (j > 0 && shadow_list[j-1] > key) begin
                        shadow_list[j] = shadow_list[j-1];
                        j--;
                    end
                    shadow_list[j] = key;
                end
                r.ok = 1'b1;
            end
            bol_pkg::CMD_REVERSE: begin
                for (i = 0; i < shadow_count / 2; i++) begin
                    key = shadow_list[i];
                    shadow_list[i] = shadow_list[shadow_count-1-i];
                    shadow_list[shadow_count-1-i] = key;
                end
                r.ok = 1'b1;
            end
            bol_pkg::CMD_CLEAR: begin
                shadow_count = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.element_count = 7'(shadow_count);
        return r;
    endfunction

    // Sample at the rising edge: log accepted requests, check strobed results.
    always @(posedge i_clk) begin : result_checker
        t_list_result predicted;
        t_list_result want;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                predicted = apply_list_command(i_command, i_item_value, i_item_position);
                pending_results.push_back(row_typed ? row_want : predicted);
            end
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, o_ok);
                        failures++;
                    end
                    if (o_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, o_read_value);
                        failures++;
                    end
                    if (o_found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, o_found_position);
                        failures++;
                    end
                    if (o_element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, o_element_count);
                        failures++;
                    end
                end
            end
        end
    end

    // Drive one request at the falling edge and hold it until it is taken.
    // An optional idle gap comes first; start is lowered only when idling.
    task automatic send_request(logic [3:0] cmd, logic signed [31:0] v, logic [6:0] pos,
                                bit typed, t_list_result want);
        while (!no_idle && $urandom_range(99) < 17) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start         <= 1'b1;
        i_command       <= cmd;
        i_item_value    <= v;
        i_item_position <= pos;
        row_typed       <= typed;
        row_want        <= want;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // Pick a value that often hits the list, so find and delete succeed.
    function automatic logic signed [31:0] pick_value();
        int k;
        k = $urandom_range(9);
        if (k < 3 && shadow_count > 0) return shadow_list[$urandom_range(shadow_count - 1)];
        if (k < 7) return 32'($signed($urandom_range(15)) - 8);
        return $urandom;
    endfunction

    t_directed_row directed_rows[$];

    function automatic t_directed_row make_row(logic [3:0] cmd, logic signed [31:0] v,
                                               logic [6:0] pos, bit typed, logic ok,
                                               logic signed [31:0] rd, logic [6:0] fp,
                                               logic [6:0] cnt);
        t_directed_row row;
        row.command = cmd;
        row.value = v;
        row.position = pos;
        row.typed = typed;
        row.want.ok = ok;
        row.want.read_value = rd;
        row.want.found_position = fp;
        row.want.element_count = cnt;
        return row;
    endfunction

    initial begin : stimulus
        int                 n;
        int                 fill_bias;
        int                 k;
        logic [3:0]         cmd;
        logic [6:0]         pos;
        t_list_result       none;
        t_directed_row      row;
        none = '{1'b0, 32'sd0, 7'd0, 7'd0};
        failures = 0;
        no_idle = 1'b0;
        shadow_count = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = bol_pkg::CMD_CLEAR;
        i_item_value = '0;
        i_item_position = '0;
        row_typed = 1'b0;
        row_want = none;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty list: pops, reads, lookups fail; sort and reverse still succeed
        directed_rows.push_back(make_row(bol_pkg::CMD_POP_BACK, 0, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_POP_FRONT, 0, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_READ_POS, 0, 0, 1, 0, -1, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_FIND, 5, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_DELETE, 5, 0, 1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_SORT, 0, 0, 1, 1, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_REVERSE, 0, 0, 1, 1, 0, 0, 0));
        // Extreme values at both ends
        directed_rows.push_back(make_row(bol_pkg::CMD_PUSH_BACK, 32'sh7fffffff,
                                         0, 1, 1, 0, 0, 1));
        directed_rows.push_back(make_row(bol_pkg::CMD_PUSH_FRONT, 32'sh80000000,
                                         0, 1, 1, 0, 0, 2));
        directed_rows.push_back(make_row(bol_pkg::CMD_READ_POS, 0, 1, 1, 1,
                                         32'sh80000000, 0, 2));
        directed_rows.push_back(make_row(bol_pkg::CMD_READ_POS, 0, 2, 1, 1,
                                         32'sh7fffffff, 0, 2));
        directed_rows.push_back(make_row(bol_pkg::CMD_READ_POS, 0, 127, 1, 0, -1, 0, 2));
        directed_rows.push_back(make_row(bol_pkg::CMD_READ_POS, 0, 3, 1, 0, -1, 0, 2));
        directed_rows.push_back(make_row(bol_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_FIND, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_REVERSE, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_SORT, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(CMD_UNKNOWN_LO, 1, 1, 1, 0, 0, 0, 4));
        directed_rows.push_back(make_row(CMD_UNKNOWN_HI, -1, 127, 1, 0, 0, 0, 4));
        directed_rows.push_back(make_row(bol_pkg::CMD_DELETE, 32'sh7fffffff,
                                         0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_POP_FRONT, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_POP_BACK, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(bol_pkg::CMD_CLEAR, 0, 0, 1, 1, 0, 0, 0));

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.command, row.value, row.position, row.typed, row.want);
        end

        // Random part: a fill bias that shifts every so often drives the list
        // from empty to full and back, so the full case is hit repeatedly.
        fill_bias = 50;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 80 == 0) fill_bias = $urandom_range(90, 10);
            no_idle = (n >= 300 && n < 500);
            if (n == 600) begin
                // Hold off until the list engine has drained
                i_start <= 1'b0;
                @(negedge i_clk);
                while (pending_results.size() != 0) @(negedge i_clk);
            end
            k = $urandom_range(99);
            if (k < fill_bias) begin
                case ($urandom_range(2))
                    0: cmd = bol_pkg::CMD_PUSH_BACK;
                    1: cmd = bol_pkg::CMD_PUSH_FRONT;
                    default: cmd = bol_pkg::CMD_INSERT;
                endcase
            end else if (k < 97) begin
                case ($urandom_range(11))
                    0, 1: cmd = bol_pkg::CMD_POP_BACK;
                    2, 3: cmd = bol_pkg::CMD_POP_FRONT;
                    4, 5: cmd = bol_pkg::CMD_READ_POS;
                    6, 7: cmd = bol_pkg::CMD_FIND;
                    8, 9: cmd = bol_pkg::CMD_DELETE;
                    10: cmd = ($urandom_range(3) == 0) ? bol_pkg::CMD_SORT
                                                      : bol_pkg::CMD_REVERSE;
                    default: cmd = ($urandom_range(7) == 0) ? bol_pkg::CMD_CLEAR
                                                           : bol_pkg::CMD_FIND;
                endcase
            end else begin
                cmd = 4'($urandom_range(int'(CMD_UNKNOWN_HI), int'(CMD_UNKNOWN_LO)));
            end
            pos = ($urandom_range(4) == 0) ? 7'($urandom)
                                           : 7'($urandom_range(shadow_count + 1));
            send_request(cmd, pick_value(), pos, 1'b0, none);
        end
        i_start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog: sorts of a full list dominate, allow ample margin
    initial begin
        #200_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
